/* sv/itkf_pkg.sv */
`timescale 1ns / 1ps
package itkf_pkg;
    localparam int FRAC_BITS = 16;
    localparam int WORD_WIDTH = 32;
    localparam int DIV_STEPS = WORD_WIDTH + FRAC_BITS;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);

    typedef logic signed [WORD_WIDTH-1:0] word_t;

    localparam word_t WORD_MAX = word_t'({1'b0, {(WORD_WIDTH-1){1'b1}}});
    localparam word_t WORD_MIN = word_t'({1'b1, {(WORD_WIDTH-1){1'b0}}});
    localparam word_t ONE_Q = word_t'(64'sd1 <<< FRAC_BITS);

    typedef enum logic [1:0] {
        REG_TIME_STEP = 2'd0,
        REG_PROCESS_NOISE = 2'd1,
        REG_MEASURE_NOISE = 2'd2
    } reg_idx_t;

    // Datapath operations issued by the controller.
    typedef enum logic [4:0] {
        OP_NONE,
        OP_INIT,   // load from the accelerometer
        OP_D,      // a = rate - bias
        OP_XA,     // xa = angle + dt*a
        OP_T,      // t = dt*P11
        OP_P01,    // p01 = P01 - t ; p10 = P10 - t
        OP_P00A,   // p00 = P00 - dt*P10
        OP_P00B,   // p00 = p00 - dt*p01 + q ; p11 = P11 + q
        OP_S,      // s = p00 + r ; eps = accel - xa
        OP_DIV0,   // start k0 = p00/s
        OP_DIV1,   // start k1 = p10/s
        OP_ANG,    // angle = xa + k0*eps
        OP_BIAS,   // bias = bias + k1*eps
        OP_SK0,
        OP_SK1,
        OP_C00,
        OP_C01,
        OP_C10,
        OP_C11
    } op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RUN,
        ST_WAIT_DIV,
        ST_OUT
    } state_t;

    typedef struct packed {
        op_t  op;
        logic load_in;
    } cmd_t;

    typedef struct packed {
        logic div_busy;
    } sts_t;

    function automatic word_t sat_wide(input logic signed [WORD_WIDTH+1:0] v);
        if (v > $signed({{2{WORD_MAX[WORD_WIDTH-1]}}, WORD_MAX}))
            return WORD_MAX;
        else if (v < $signed({{2{WORD_MIN[WORD_WIDTH-1]}}, WORD_MIN}))
            return WORD_MIN;
        else
            return v[WORD_WIDTH-1:0];
    endfunction

    function automatic word_t add_s(input word_t a, input word_t b);
        return sat_wide((WORD_WIDTH+2)'(a) + (WORD_WIDTH+2)'(b));
    endfunction

    function automatic word_t sub_s(input word_t a, input word_t b);
        return sat_wide((WORD_WIDTH+2)'(a) - (WORD_WIDTH+2)'(b));
    endfunction

    function automatic logic [WORD_WIDTH:0] mag(input word_t v);
        logic [WORD_WIDTH:0] e;
        e = {v[WORD_WIDTH-1], v};
        return v[WORD_WIDTH-1] ? (~e + 1'b1) : e;
    endfunction

    // Apply a sign to a magnitude with a saturation flag.
    function automatic word_t signed_sat(input logic [WORD_WIDTH:0] m, input logic ovf,
                                         input logic neg);
        logic big;
        big = ovf || m[WORD_WIDTH] || m[WORD_WIDTH-1];
        if (neg)
            return big ? WORD_MIN : word_t'(~m[WORD_WIDTH-1:0] + 1'b1);
        else
            return big ? WORD_MAX : word_t'(m[WORD_WIDTH-1:0]);
    endfunction
endpackage

/* sv/itkf_if.sv */
`timescale 1ns / 1ps
interface itkf_in_if;
    logic valid;
    logic ready;
    logic signed [31:0] gyro_rate;
    logic signed [31:0] accel_angle;
    logic start_of_run;
    modport source (output valid, gyro_rate, accel_angle, start_of_run, input ready);
    modport sink (input valid, gyro_rate, accel_angle, start_of_run, output ready);
endinterface

interface itkf_out_if;
    logic valid;
    logic ready;
    logic signed [31:0] filtered_angle;
    modport source (output valid, filtered_angle, input ready);
    modport sink (input valid, filtered_angle, output ready);
endinterface

interface itkf_cfg_if;
    logic valid;
    logic ready;
    logic [1:0] index;
    logic [31:0] data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

/* sv/itkf_ctrl.sv */
`timescale 1ns / 1ps
module itkf_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                in_start,
    output logic                in_ready,
    output logic                out_valid,
    input  logic                out_ready,
    input  itkf_pkg::sts_t      sts,
    output itkf_pkg::cmd_t      cmd
);
    itkf_pkg::state_t state_reg, state_next;
    itkf_pkg::op_t    op_reg, op_next;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg <= itkf_pkg::ST_IDLE;
            op_reg <= itkf_pkg::OP_NONE;
        end else begin
            state_reg <= state_next;
            op_reg <= op_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        op_next = op_reg;
        in_ready = 1'b0;
        out_valid = 1'b0;
        cmd.op = itkf_pkg::OP_NONE;
        cmd.load_in = 1'b0;
        case (state_reg)
            itkf_pkg::ST_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    cmd.load_in = 1'b1;
                    state_next = itkf_pkg::ST_RUN;
                    op_next = in_start ? itkf_pkg::OP_INIT : itkf_pkg::OP_D;
                end
            end
            itkf_pkg::ST_RUN: begin
                cmd.op = op_reg;
                case (op_reg)
                    itkf_pkg::OP_INIT, itkf_pkg::OP_C11: state_next = itkf_pkg::ST_OUT;
                    itkf_pkg::OP_DIV0, itkf_pkg::OP_DIV1: begin
                        state_next = itkf_pkg::ST_WAIT_DIV;
                        op_next = itkf_pkg::op_t'(op_reg + 1'b1);
                    end
                    default: op_next = itkf_pkg::op_t'(op_reg + 1'b1);
                endcase
            end
            itkf_pkg::ST_WAIT_DIV: begin
                if (!sts.div_busy)
                    state_next = itkf_pkg::ST_RUN;
            end
            itkf_pkg::ST_OUT: begin
                out_valid = 1'b1;
                if (out_ready)
                    state_next = itkf_pkg::ST_IDLE;
            end
            default: state_next = itkf_pkg::ST_IDLE;
        endcase
    end
endmodule

/* sv/itkf_dp.sv */
`timescale 1ns / 1ps
module itkf_dp (
    input  logic                clk,
    input  logic                rst_n,
    input  itkf_pkg::cmd_t      cmd,
    output itkf_pkg::sts_t      sts,
    input  logic signed [31:0]  gyro_rate,
    input  logic signed [31:0]  accel_angle,
    input  logic                cfg_we,
    input  logic [1:0]          cfg_index,
    input  logic [31:0]         cfg_data,
    output logic signed [31:0]  filtered_angle
);
    localparam int W = itkf_pkg::WORD_WIDTH;
    localparam int F = itkf_pkg::FRAC_BITS;

    logic [15:0] dt_reg;
    logic [30:0] q_reg, r_reg;
    itkf_pkg::word_t angle_reg, bias_reg, c00_reg, c01_reg, c10_reg, c11_reg;
    itkf_pkg::word_t rate_reg, accel_reg;
    itkf_pkg::word_t a_reg, xa_reg, t_reg, p00_reg, p01_reg, p10_reg, p11_reg;
    itkf_pkg::word_t s_reg, eps_reg, k0_reg, k1_reg, sk0_reg, sk1_reg;

    itkf_pkg::word_t dt_w, q_w, r_w;
    assign dt_w = itkf_pkg::word_t'({1'b0, dt_reg});
    assign q_w = itkf_pkg::word_t'({1'b0, q_reg});
    assign r_w = itkf_pkg::word_t'({1'b0, r_reg});

    // Shared multiplier with combinational product.
    itkf_pkg::word_t ma, mb, prod;
    logic [W:0] mag_a, mag_b;
    logic [2*W+1:0] full;
    logic [2*W+1:0] rounded;
    always_comb begin
        ma = dt_w;
        mb = a_reg;
        case (cmd.op)
            itkf_pkg::OP_XA:   begin ma = dt_w;    mb = a_reg;    end
            itkf_pkg::OP_T:    begin ma = dt_w;    mb = c11_reg;  end
            itkf_pkg::OP_P00A: begin ma = dt_w;    mb = c10_reg;  end
            itkf_pkg::OP_P00B: begin ma = dt_w;    mb = p01_reg;  end
            itkf_pkg::OP_ANG:  begin ma = k0_reg;  mb = eps_reg;  end
            itkf_pkg::OP_BIAS: begin ma = k1_reg;  mb = eps_reg;  end
            itkf_pkg::OP_SK0:  begin ma = s_reg;   mb = k0_reg;   end
            itkf_pkg::OP_SK1:  begin ma = s_reg;   mb = k1_reg;   end
            itkf_pkg::OP_C00:  begin ma = sk0_reg; mb = k0_reg;   end
            itkf_pkg::OP_C01:  begin ma = sk0_reg; mb = k1_reg;   end
            itkf_pkg::OP_C10:  begin ma = sk1_reg; mb = k0_reg;   end
            itkf_pkg::OP_C11:  begin ma = sk1_reg; mb = k1_reg;   end
            default:           begin ma = dt_w;    mb = a_reg;    end
        endcase
        mag_a = itkf_pkg::mag(ma);
        mag_b = itkf_pkg::mag(mb);
        full = mag_a * mag_b;
        rounded = full + ((2*W+2)'(1) << (F - 1));
        prod = itkf_pkg::signed_sat(rounded[F+W:F], |rounded[2*W+1:F+W+1],
                                    ma[W-1] ^ mb[W-1]);
    end

    // Serial divider: one quotient bit per cycle over integer and fraction bits.
    logic [W:0] dv_den_reg, dv_rem_reg;
    logic [W+F-1:0] dv_num_reg;
    logic [W:0] dv_q_reg;
    logic dv_neg_reg, dv_zero_reg, dv_busy_reg, dv_sel_reg;
    logic [itkf_pkg::DIV_CNT_W-1:0] dv_cnt_reg;
    logic [W+1:0] dv_try;
    logic [W:0] dv_shift;
    logic [W:0] dv_num_mag;
    itkf_pkg::word_t dv_num_src, dv_result;
    assign dv_num_src = (cmd.op == itkf_pkg::OP_DIV1) ? p10_reg : p00_reg;
    assign dv_num_mag = itkf_pkg::mag(dv_num_src);
    assign dv_shift = {dv_rem_reg[W-1:0], dv_num_reg[W+F-1]};
    assign dv_try = {1'b0, dv_shift} - {1'b0, dv_den_reg};
    assign dv_result = dv_zero_reg ? '0 : itkf_pkg::signed_sat(dv_q_reg, 1'b0, dv_neg_reg);
    assign sts.div_busy = dv_busy_reg;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            dv_busy_reg <= 1'b0;
            dv_cnt_reg <= '0;
            dt_reg <= 16'd6554;
            q_reg <= 31'd6554;
            r_reg <= 31'd262144;
            angle_reg <= '0;
            bias_reg <= '0;
            c00_reg <= itkf_pkg::ONE_Q;
            c01_reg <= '0;
            c10_reg <= '0;
            c11_reg <= itkf_pkg::ONE_Q;
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    itkf_pkg::REG_TIME_STEP:     dt_reg <= cfg_data[15:0];
                    itkf_pkg::REG_PROCESS_NOISE: q_reg <= cfg_data[30:0];
                    itkf_pkg::REG_MEASURE_NOISE: r_reg <= cfg_data[30:0];
                    default: ;
                endcase
            end
            if (cmd.op == itkf_pkg::OP_DIV0 || cmd.op == itkf_pkg::OP_DIV1) begin
                dv_busy_reg <= 1'b1;
                dv_sel_reg <= (cmd.op == itkf_pkg::OP_DIV1);
                dv_den_reg <= itkf_pkg::mag(s_reg);
                dv_zero_reg <= (s_reg == '0);
                dv_neg_reg <= dv_num_src[W-1] ^ s_reg[W-1];
                dv_num_reg <= {dv_num_mag[W-1:0], {F{1'b0}}};
                dv_rem_reg <= '0;
                dv_q_reg <= '0;
                dv_cnt_reg <= '0;
            end else if (dv_busy_reg) begin
                // Quotient bits beyond the word width only saturate, held sticky in the top bit.
                if (!dv_try[W+1]) begin
                    dv_rem_reg <= dv_try[W:0];
                    dv_q_reg <= {dv_q_reg[W] | dv_q_reg[W-1], dv_q_reg[W-2:0], 1'b1};
                end else begin
                    dv_rem_reg <= dv_shift;
                    dv_q_reg <= {dv_q_reg[W] | dv_q_reg[W-1], dv_q_reg[W-2:0], 1'b0};
                end
                dv_num_reg <= {dv_num_reg[W+F-2:0], 1'b0};
                dv_cnt_reg <= dv_cnt_reg + 1'b1;
                if (dv_cnt_reg == (itkf_pkg::DIV_CNT_W)'(itkf_pkg::DIV_STEPS - 1)) begin
                    dv_busy_reg <= 1'b0;
                end
            end
            if (!dv_busy_reg && dv_cnt_reg == (itkf_pkg::DIV_CNT_W)'(itkf_pkg::DIV_STEPS)) begin
                if (dv_sel_reg) k1_reg <= dv_result; else k0_reg <= dv_result;
                dv_cnt_reg <= '0;
            end else if (dv_busy_reg &&
                         dv_cnt_reg == (itkf_pkg::DIV_CNT_W)'(itkf_pkg::DIV_STEPS - 1)) begin
                dv_cnt_reg <= (itkf_pkg::DIV_CNT_W)'(itkf_pkg::DIV_STEPS);
            end
            case (cmd.op)
                itkf_pkg::OP_INIT: begin
                    angle_reg <= accel_reg;
                    bias_reg <= '0;
                    c00_reg <= itkf_pkg::ONE_Q;
                    c01_reg <= '0;
                    c10_reg <= '0;
                    c11_reg <= itkf_pkg::ONE_Q;
                end
                itkf_pkg::OP_ANG:  angle_reg <= itkf_pkg::add_s(xa_reg, prod);
                itkf_pkg::OP_BIAS: bias_reg <= itkf_pkg::add_s(bias_reg, prod);
                itkf_pkg::OP_C00:  c00_reg <= itkf_pkg::sub_s(p00_reg, prod);
                itkf_pkg::OP_C01:  c01_reg <= itkf_pkg::sub_s(p01_reg, prod);
                itkf_pkg::OP_C10:  c10_reg <= itkf_pkg::sub_s(p10_reg, prod);
                itkf_pkg::OP_C11:  c11_reg <= itkf_pkg::sub_s(p11_reg, prod);
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk) begin
        if (cmd.load_in) begin
            rate_reg <= gyro_rate;
            accel_reg <= accel_angle;
        end
        case (cmd.op)
            itkf_pkg::OP_D:    a_reg <= itkf_pkg::sub_s(rate_reg, bias_reg);
            itkf_pkg::OP_XA:   xa_reg <= itkf_pkg::add_s(angle_reg, prod);
            itkf_pkg::OP_T:    t_reg <= prod;
            itkf_pkg::OP_P01: begin
                p01_reg <= itkf_pkg::sub_s(c01_reg, t_reg);
                p10_reg <= itkf_pkg::sub_s(c10_reg, t_reg);
            end
            itkf_pkg::OP_P00A: p00_reg <= itkf_pkg::sub_s(c00_reg, prod);
            itkf_pkg::OP_P00B: begin
                p00_reg <= itkf_pkg::add_s(itkf_pkg::sub_s(p00_reg, prod), q_w);
                p11_reg <= itkf_pkg::add_s(c11_reg, q_w);
            end
            itkf_pkg::OP_S: begin
                s_reg <= itkf_pkg::add_s(p00_reg, r_w);
                eps_reg <= itkf_pkg::sub_s(accel_reg, xa_reg);
            end
            itkf_pkg::OP_SK0:  sk0_reg <= prod;
            itkf_pkg::OP_SK1:  sk1_reg <= prod;
            default: ;
        endcase
    end

    assign filtered_angle = angle_reg[31:0];
endmodule

/* sv/imu_tilt_kalman_filter_core.sv */
`timescale 1ns / 1ps
// Sequence: an item with the start flag loads the accelerometer angle as the new
// angle and resets bias and covariance; a normal item runs the predict, update and
// covariance operations, including two 48-step serial divisions, before its result.
// Throughput: one item at a time, next transfer once the result is taken.
// Reset (rst_n, asynchronous, active low) restores the configuration registers to
// their defaults, angle and bias to zero and the covariance to identity.
module imu_tilt_kalman_filter_core (
    input logic       clk,
    input logic       rst_n,
    itkf_in_if.sink   in_ch,
    itkf_out_if.source out_ch,
    itkf_cfg_if.sink  cfg
);
    itkf_pkg::cmd_t cmd;
    itkf_pkg::sts_t sts;

    // Configuration is always taken; the datapath holds the registers.
    assign cfg.ready = 1'b1;

    // The controller steps the datapath through predict, update and covariance ops.
    itkf_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_start  (in_ch.start_of_run),
        .in_ready  (in_ch.ready),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    itkf_dp u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .sts            (sts),
        .gyro_rate      (in_ch.gyro_rate),
        .accel_angle    (in_ch.accel_angle),
        .cfg_we         (cfg.valid),
        .cfg_index      (cfg.index),
        .cfg_data       (cfg.data),
        .filtered_angle (out_ch.filtered_angle)
    );
endmodule

/* sv/itkf_checker.sv */
`timescale 1ns / 1ps
module itkf_sva (
    input logic clk,
    input logic rst_n,
    input logic in_valid,
    input logic in_ready,
    input logic out_valid,
    input logic out_ready,
    input logic [31:0] out_angle
);
    a_no_in_while_out: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !in_ready) else $error("input taken while result pending");
    a_out_after_in: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !out_valid) else $error("result too early");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(out_angle)))
        else $error("result dropped");
endmodule

bind imu_tilt_kalman_filter_core itkf_sva u_chk (
    .clk(clk), .rst_n(rst_n), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .out_angle(out_ch.filtered_angle)
);
